// ===== sv/crw_pkg.sv =====
package crw_pkg;

    localparam int INDEX_W = 6;
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 16;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef enum logic [2:0] {
        KIND_LOADED  = 3'd0,
        KIND_WROTE   = 3'd1,
        KIND_SKIPPED = 3'd2,
        KIND_BUSY    = 3'd3,
        KIND_IDLE    = 3'd4,
        KIND_READ    = 3'd5
    } kind_t;

endpackage

// ===== sv/crw_req_if.sv =====
interface crw_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [crw_pkg::INDEX_W-1:0]  index;
    logic [crw_pkg::BYTE_W-1:0]   value;
    logic                         final_byte;
    logic                         store_busy;

    modport source (output valid, output op, output index, output value,
                    output final_byte, output store_busy, input ready);
    modport sink   (input valid, input op, input index, input value,
                    input final_byte, input store_busy, output ready);
endinterface

// ===== sv/crw_rsp_if.sv =====
interface crw_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   kind;
    logic [crw_pkg::INDEX_W-1:0]  address;
    logic [crw_pkg::BYTE_W-1:0]   data;
    logic                         run_end;
    logic                         checksum_ok;
    logic                         writing;

    modport source (output valid, output kind, output address, output data,
                    output run_end, output checksum_ok, output writing, input ready);
    modport sink   (input valid, input kind, input address, input data,
                    input run_end, input checksum_ok, input writing, output ready);
endinterface

// ===== sv/checksummed_record_nv_writer.sv =====
// channel | dir | handshake     | carries
// req     | in  | valid / ready | op, index, value, final_byte, store_busy
// rsp     | out | valid / ready | kind, address, data, run_end, checksum_ok, writing
//
// one request at a time; a result sits in an output register while the next request is taken
// load and tick: a memory read or write, then the result register
// final load: the staged payload is summed one byte per cycle
// read: one byte per cycle off the store's single read port, while the result register is free
// reset erases the store through per-entry valid bits, so there is no clearing pass
// a stalled result register holds the sequencer in place until the result is taken
module checksummed_record_nv_writer #(
    parameter int RECORD_BYTES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    crw_req_if.sink          req,
    crw_rsp_if.source        rsp
);

    localparam int PAYLOAD = RECORD_BYTES - 2;
    localparam int AW      = $clog2(RECORD_BYTES);
    localparam int CW      = $clog2(RECORD_BYTES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SUM,
        S_SUM_LO,
        S_SUM_HI,
        S_TICK,
        S_READ
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [crw_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [crw_pkg::BYTE_W-1:0]   lo_reg, lo_next;
    logic                         busy_reg, busy_next;
    crw_pkg::kind_t               res_kind_reg, res_kind_next;
    logic [crw_pkg::INDEX_W-1:0]  res_addr_reg, res_addr_next;
    logic [crw_pkg::BYTE_W-1:0]   res_data_reg, res_data_next;

    logic                         out_valid_reg, out_valid_next;
    crw_pkg::kind_t               out_kind_reg, out_kind_next;
    logic [crw_pkg::INDEX_W-1:0]  out_addr_reg, out_addr_next;
    logic [crw_pkg::BYTE_W-1:0]   out_data_reg, out_data_next;
    logic                         out_end_reg, out_end_next;
    logic                         out_ok_reg, out_ok_next;
    logic                         out_writing_reg, out_writing_next;

    // staging buffer
    logic [crw_pkg::BYTE_W-1:0]   sb_mem [RECORD_BYTES];
    logic                         sb_we, sb_re;
    logic [AW-1:0]                sb_waddr, sb_raddr;
    logic [crw_pkg::BYTE_W-1:0]   sb_wdata, sb_rdata_reg;

    // nonvolatile store, erased entries tracked by valid bits
    logic [crw_pkg::BYTE_W-1:0]   nv_mem [RECORD_BYTES];
    logic [RECORD_BYTES-1:0]      nv_valid_reg;
    logic                         nv_we, nv_re;
    logic [AW-1:0]                nv_waddr, nv_raddr;
    logic [crw_pkg::BYTE_W-1:0]   nv_wdata, nv_rdata_reg;
    logic                         nv_rvalid_reg;

    logic                         req_fire;
    logic                         out_free;
    logic                         index_in_payload;
    logic                         last_rd;
    logic [CW-1:0]                cnt_inc;
    logic [CW-1:0]                pos_inc;
    logic [crw_pkg::BYTE_W-1:0]   nv_byte;

    assign req.ready       = (state_reg == S_IDLE);
    assign req_fire        = req.valid && req.ready;
    assign out_free        = !out_valid_reg || rsp.ready;
    assign index_in_payload = ({1'b0, req.index} < 7'(PAYLOAD));
    assign last_rd         = (cnt_reg == CW'(RECORD_BYTES - 1));
    assign cnt_inc         = cnt_reg + 1'b1;
    assign pos_inc         = pos_reg + 1'b1;
    assign nv_byte         = nv_rvalid_reg ? nv_rdata_reg : 8'hFF;

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.address     = out_addr_reg;
    assign rsp.data        = out_data_reg;
    assign rsp.run_end     = out_end_reg;
    assign rsp.checksum_ok = out_ok_reg;
    assign rsp.writing     = out_writing_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pos_next         = pos_reg;
        sum_next         = sum_reg;
        lo_next          = lo_reg;
        busy_next        = busy_reg;
        res_kind_next    = res_kind_reg;
        res_addr_next    = res_addr_reg;
        res_data_next    = res_data_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_addr_next    = out_addr_reg;
        out_data_next    = out_data_reg;
        out_end_next     = out_end_reg;
        out_ok_next      = out_ok_reg;
        out_writing_next = out_writing_reg;
        sb_we            = 1'b0;
        sb_waddr         = req.index[AW-1:0];
        sb_wdata         = req.value;
        sb_re            = 1'b0;
        sb_raddr         = cnt_reg[AW-1:0];
        nv_we            = 1'b0;
        nv_waddr         = pos_reg[AW-1:0];
        nv_wdata         = sb_rdata_reg;
        nv_re            = 1'b0;
        nv_raddr         = cnt_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    busy_next = req.store_busy;
                    priority case (req.op)
                        crw_pkg::OP_LOAD:
                        begin
                            // a load drops any pending write
                            pos_next      = CW'(RECORD_BYTES);
                            sb_we         = index_in_payload;
                            res_kind_next = crw_pkg::KIND_LOADED;
                            res_addr_next = req.index;
                            res_data_next = req.value;
                            if (req.final_byte)
                            begin
                                cnt_next   = '0;
                                sum_next   = '0;
                                state_next = S_SUM;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        crw_pkg::OP_TICK:
                        begin
                            if (pos_reg >= CW'(RECORD_BYTES))
                            begin
                                res_kind_next = crw_pkg::KIND_IDLE;
                                res_addr_next = '0;
                                res_data_next = '0;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                sb_re      = 1'b1;
                                sb_raddr   = pos_reg[AW-1:0];
                                nv_re      = 1'b1;
                                nv_raddr   = pos_reg[AW-1:0];
                                state_next = S_TICK;
                            end
                        end
                        crw_pkg::OP_READ:
                        begin
                            nv_re      = 1'b1;
                            nv_raddr   = '0;
                            cnt_next   = '0;
                            sum_next   = '0;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            res_kind_next = crw_pkg::KIND_IDLE;
                            res_addr_next = '0;
                            res_data_next = '0;
                            state_next    = S_EMIT;
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = res_kind_reg;
                    out_addr_next    = res_addr_reg;
                    out_data_next    = res_data_reg;
                    out_end_next     = 1'b0;
                    out_ok_next      = 1'b0;
                    out_writing_next = (pos_reg < CW'(RECORD_BYTES));
                    state_next       = S_IDLE;
                end
            end

            S_SUM:
            begin
                // add happens in the cycle after the read
                if (cnt_reg < CW'(PAYLOAD))
                begin
                    sb_re    = 1'b1;
                    sb_raddr = cnt_reg[AW-1:0];
                end
                if (cnt_reg != '0)
                begin
                    sum_next = sum_reg + {8'h00, sb_rdata_reg};
                end
                cnt_next = cnt_inc;
                if (cnt_reg == CW'(PAYLOAD))
                begin
                    state_next = S_SUM_LO;
                end
            end

            S_SUM_LO:
            begin
                sb_we      = 1'b1;
                sb_waddr   = AW'(PAYLOAD);
                sb_wdata   = sum_reg[7:0];
                state_next = S_SUM_HI;
            end

            S_SUM_HI:
            begin
                sb_we      = 1'b1;
                sb_waddr   = AW'(PAYLOAD + 1);
                sb_wdata   = sum_reg[15:8];
                pos_next   = '0;
                state_next = S_EMIT;
            end

            S_TICK:
            begin
                if (out_free)
                begin
                    if (nv_byte == sb_rdata_reg)
                    begin
                        out_kind_next = crw_pkg::KIND_SKIPPED;
                        pos_next      = pos_inc;
                    end
                    else if (busy_reg)
                    begin
                        out_kind_next = crw_pkg::KIND_BUSY;
                    end
                    else
                    begin
                        nv_we         = 1'b1;
                        out_kind_next = crw_pkg::KIND_WROTE;
                        pos_next      = pos_inc;
                    end
                    out_valid_next   = 1'b1;
                    out_addr_next    = 6'(pos_reg);
                    out_data_next    = sb_rdata_reg;
                    out_end_next     = 1'b0;
                    out_ok_next      = 1'b0;
                    out_writing_next = (pos_next < CW'(RECORD_BYTES));
                    state_next       = S_IDLE;
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = crw_pkg::KIND_READ;
                    out_addr_next    = 6'(cnt_reg);
                    out_data_next    = nv_byte;
                    out_end_next     = last_rd;
                    out_ok_next      = last_rd && (sum_reg == {nv_byte, lo_reg});
                    out_writing_next = (pos_reg < CW'(RECORD_BYTES));
                    if (cnt_reg < CW'(PAYLOAD))
                    begin
                        sum_next = sum_reg + {8'h00, nv_byte};
                    end
                    if (cnt_reg == CW'(PAYLOAD))
                    begin
                        lo_next = nv_byte;
                    end
                    if (last_rd)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        nv_re    = 1'b1;
                        nv_raddr = cnt_inc[AW-1:0];
                        cnt_next = cnt_inc;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            pos_reg         <= CW'(RECORD_BYTES);
            sum_reg         <= '0;
            lo_reg          <= '0;
            busy_reg        <= 1'b0;
            res_kind_reg    <= crw_pkg::KIND_IDLE;
            res_addr_reg    <= '0;
            res_data_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= crw_pkg::KIND_IDLE;
            out_addr_reg    <= '0;
            out_data_reg    <= '0;
            out_end_reg     <= 1'b0;
            out_ok_reg      <= 1'b0;
            out_writing_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            lo_reg          <= lo_next;
            busy_reg        <= busy_next;
            res_kind_reg    <= res_kind_next;
            res_addr_reg    <= res_addr_next;
            res_data_reg    <= res_data_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_addr_reg    <= out_addr_next;
            out_data_reg    <= out_data_next;
            out_end_reg     <= out_end_next;
            out_ok_reg      <= out_ok_next;
            out_writing_reg <= out_writing_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_valid_reg <= '0;
        end
        else if (nv_we)
        begin
            nv_valid_reg[nv_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sb_we)
        begin
            sb_mem[sb_waddr] <= sb_wdata;
        end
        if (sb_re)
        begin
            sb_rdata_reg <= sb_mem[sb_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nv_we)
        begin
            nv_mem[nv_waddr] <= nv_wdata;
        end
        if (nv_re)
        begin
            nv_rdata_reg  <= nv_mem[nv_raddr];
            nv_rvalid_reg <= nv_valid_reg[nv_raddr];
        end
    end

endmodule

// ===== sv/crw_checker.sv =====
module crw_checker #(
    parameter int RECORD_BYTES = 16
) (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_kind,
    input logic [5:0] rsp_address,
    input logic [7:0] rsp_data,
    input logic       rsp_run_end,
    input logic       rsp_checksum_ok,
    input logic       rsp_writing
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
            && $stable(rsp_address) && $stable(rsp_data))
        else $error("result changed while stalled");

    // a read run ends on the last record byte
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_run_end |->
            rsp_kind == crw_pkg::KIND_READ && rsp_address == 6'(RECORD_BYTES - 1))
        else $error("run end off the last read byte");

    // checksum flag only on a run end
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_checksum_ok |-> rsp_run_end)
        else $error("checksum flag outside run end");

    // writing stops only after the last record byte is handled
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_writing
            && (rsp_kind == crw_pkg::KIND_WROTE || rsp_kind == crw_pkg::KIND_SKIPPED)
            |-> rsp_address == 6'(RECORD_BYTES - 1))
        else $error("writing stopped early");

    // idle results carry nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind == crw_pkg::KIND_IDLE |->
            rsp_address == '0 && rsp_data == '0)
        else $error("idle result with content");

endmodule

bind checksummed_record_nv_writer crw_checker #(
    .RECORD_BYTES(RECORD_BYTES)
) u_crw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_address    (rsp.address),
    .rsp_data       (rsp.data),
    .rsp_run_end    (rsp.run_end),
    .rsp_checksum_ok(rsp.checksum_ok),
    .rsp_writing    (rsp.writing)
);
